// ===== src/dgsp_pkg.sv =====
// Shared types and constants for the dense-graph shortest path unit.
// No dependencies; every other file imports this package.
package dgsp_pkg;

   localparam int CMD_W      = 2;
   localparam int VTX_W      = 6;
   localparam int WGT_IN_W   = 16;
   localparam int DIST_OUT_W = 24;
   localparam int COUNT_W    = 7;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   localparam logic [COUNT_W-1:0]    VERTEX_COUNT_RESET = 7'd64;
   localparam logic [CSR_ADDR_W-1:0] CSR_VERTEX_COUNT   = 3'd0;

   localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd0;
   localparam logic [CMD_W-1:0] CMD_SET   = 2'd1;
   localparam logic [CMD_W-1:0] CMD_RUN   = 2'd2;

   typedef struct packed {
      logic [CMD_W-1:0]    command;
      logic [VTX_W-1:0]    endpoint_a;
      logic [VTX_W-1:0]    endpoint_b;
      logic [WGT_IN_W-1:0] edge_weight;
   } req_type;

   typedef struct packed {
      logic [VTX_W-1:0]      vertex_index;
      logic [DIST_OUT_W-1:0] path_distance;
      logic                  last_vertex;
   } rsp_type;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_SET_AB,
      ST_SET_BA,
      ST_INIT,
      ST_RELAX,
      ST_RELAX_WAIT,
      ST_EMIT,
      ST_EMIT_WAIT
   } ctl_state_type;

   typedef enum logic [2:0] {
      DP_NONE,
      DP_CLEAR,
      DP_LOAD,
      DP_SET_AB,
      DP_SET_BA,
      DP_INIT,
      DP_RELAX,
      DP_EMIT
   } dp_op_type;

   typedef struct packed {
      dp_op_type op;
   } dp_cmd_type;

   typedef struct packed {
      logic idx_last;
      logic clr_last;
      logic pipe_busy;
      logic rounds_done;
   } dp_status_type;

endpackage

// ===== src/dgsp_ctrl.sv =====
// Sequencer for the shortest path unit: clear sweep, edge writes, run passes.
// Depends on dgsp_pkg; drives dgsp_datapath through dp_cmd_type.
module dgsp_ctrl import dgsp_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [CMD_W-1:0] command,
   input  dp_status_type    status,
   output dp_cmd_type       cmd,
   output logic             busy
);

   ctl_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR: begin
            if (status.clr_last) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (start) begin
               case (command)
                  CMD_CLEAR: state_in = ST_CLEAR;
                  CMD_SET:   state_in = ST_SET_AB;
                  CMD_RUN:   state_in = ST_INIT;
                  default:   state_in = ST_IDLE;
               endcase
            end
         end
         ST_SET_AB: state_in = ST_SET_BA;
         ST_SET_BA: state_in = ST_IDLE;
         ST_INIT: begin
            if (status.idx_last) state_in = ST_RELAX;
         end
         ST_RELAX: begin
            if (status.idx_last) state_in = ST_RELAX_WAIT;
         end
         ST_RELAX_WAIT: begin
            // round counter is updated by the time the pipe drains
            if (!status.pipe_busy) begin
               state_in = status.rounds_done ? ST_EMIT : ST_RELAX;
            end
         end
         ST_EMIT: begin
            if (status.idx_last) state_in = ST_EMIT_WAIT;
         end
         ST_EMIT_WAIT: begin
            if (!status.pipe_busy) state_in = ST_IDLE;
         end
         default: state_in = ST_CLEAR;
      endcase
   end

   always_comb begin
      cmd.op = DP_NONE;
      busy   = (state_ff != ST_IDLE);
      case (state_ff)
         ST_CLEAR:  cmd.op = DP_CLEAR;
         ST_IDLE:   cmd.op = start ? DP_LOAD : DP_NONE;
         ST_SET_AB: cmd.op = DP_SET_AB;
         ST_SET_BA: cmd.op = DP_SET_BA;
         ST_INIT:   cmd.op = DP_INIT;
         ST_RELAX:  cmd.op = DP_RELAX;
         ST_EMIT:   cmd.op = DP_EMIT;
         default:   cmd.op = DP_NONE;
      endcase
   end

endmodule

// ===== src/dgsp_datapath.sv =====
// Datapath of the shortest path unit: weight matrix, distance table,
// relax/select pipeline and result word. Depends on dgsp_pkg.
module dgsp_datapath import dgsp_pkg::*; #(
   parameter int MAX_VERTICES  = 64,
   parameter int WEIGHT_BITS   = 16,
   parameter int DISTANCE_BITS = 24
) (
   input  logic               clock,
   input  logic               reset,
   input  dp_cmd_type         cmd,
   output dp_status_type      status,
   input  req_type            req,
   input  logic [COUNT_W-1:0] vertex_count,
   output logic               rsp_valid,
   output rsp_type            rsp
);

   localparam int VW     = $clog2(MAX_VERTICES);
   localparam int AW     = 2 * VW;
   localparam int WDEPTH = 1 << AW;
   localparam int SW     = ((DISTANCE_BITS > WEIGHT_BITS) ? DISTANCE_BITS : WEIGHT_BITS) + 1;
   localparam logic [DISTANCE_BITS-1:0] DIST_INF = '1;

   // active vertex count, clamped
   logic [31:0]   n_clamp;
   logic [VW-1:0] last_idx;

   always_comb begin
      n_clamp = 32'(vertex_count);
      if (n_clamp < 32'd2) n_clamp = 32'd2;
      if (n_clamp > 32'(MAX_VERTICES)) n_clamp = 32'(MAX_VERTICES);
      last_idx = VW'(n_clamp - 32'd1);
   end

   // latched request word
   req_type req_ff;
   always_ff @(posedge clock) begin
      if (cmd.op == DP_LOAD) req_ff <= req;
   end

   logic [VW+VTX_W-1:0]              a_ext, b_ext;
   logic [VW-1:0]                    a_idx, b_idx;
   logic                             ends_ok;
   logic [WEIGHT_BITS+WGT_IN_W-1:0]  w_ext;
   logic [WEIGHT_BITS-1:0]           w_set;

   assign a_ext   = {{VW{1'b0}}, req_ff.endpoint_a};
   assign b_ext   = {{VW{1'b0}}, req_ff.endpoint_b};
   assign a_idx   = a_ext[VW-1:0];
   assign b_idx   = b_ext[VW-1:0];
   assign ends_ok = (32'(req_ff.endpoint_a) < 32'(MAX_VERTICES)) &&
                    (32'(req_ff.endpoint_b) < 32'(MAX_VERTICES));
   assign w_ext   = {{WEIGHT_BITS{1'b0}}, req_ff.edge_weight};
   assign w_set   = w_ext[WEIGHT_BITS-1:0];

   // scan counters
   logic [VW-1:0] idx_ff, idx_in;
   logic [AW-1:0] clr_ff, clr_in;
   logic          idx_hit;

   assign idx_hit = (idx_ff == last_idx);

   always_comb begin
      idx_in = idx_ff;
      clr_in = clr_ff;
      case (cmd.op)
         DP_INIT, DP_RELAX, DP_EMIT: idx_in = idx_hit ? '0 : idx_ff + 1'b1;
         DP_CLEAR:                   clr_in = clr_ff + 1'b1;
         default:                    ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff <= '0;
         clr_ff <= '0;
      end else begin
         idx_ff <= idx_in;
         clr_ff <= clr_in;
      end
   end

   // run state
   logic [MAX_VERTICES-1:0]  vis_ff;
   logic [VW-1:0]            u_ff;
   logic [DISTANCE_BITS-1:0] du_ff;
   logic [VW-1:0]            round_ff;
   logic                     found_ff;
   logic [VW-1:0]            cand_idx_ff;
   logic [DISTANCE_BITS-1:0] cand_dist_ff;

   // weight matrix, row = source vertex
   logic [WEIGHT_BITS-1:0] wmem [WDEPTH];
   logic                   wmem_we;
   logic [AW-1:0]          wmem_waddr;
   logic [WEIGHT_BITS-1:0] wmem_wdata;
   logic [WEIGHT_BITS-1:0] w_q;

   always_comb begin
      wmem_we    = 1'b0;
      wmem_waddr = clr_ff;
      wmem_wdata = '0;
      case (cmd.op)
         DP_CLEAR: wmem_we = 1'b1;
         DP_SET_AB: begin
            wmem_we    = ends_ok;
            wmem_waddr = {a_idx, b_idx};
            wmem_wdata = w_set;
         end
         DP_SET_BA: begin
            wmem_we    = ends_ok;
            wmem_waddr = {b_idx, a_idx};
            wmem_wdata = w_set;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (wmem_we) wmem[wmem_waddr] <= wmem_wdata;
      w_q <= wmem[{u_ff, idx_ff}];
   end

   // pipeline registers
   logic                     s1_vld_ff, s1_emit_ff, s1_last_ff;
   logic [VW-1:0]            s1_idx_ff;
   logic                     s2_vld_ff, s2_vis_ff, s2_last_ff;
   logic [VW-1:0]            s2_idx_ff;
   logic [DISTANCE_BITS-1:0] s2_dist_ff;

   // distance table
   logic [DISTANCE_BITS-1:0] dmem [MAX_VERTICES];
   logic                     dmem_we;
   logic [VW-1:0]            dmem_waddr;
   logic [DISTANCE_BITS-1:0] dmem_wdata;
   logic [DISTANCE_BITS-1:0] d_q;

   always_comb begin
      dmem_we    = s2_vld_ff;
      dmem_waddr = s2_idx_ff;
      dmem_wdata = s2_dist_ff;
      if (cmd.op == DP_INIT) begin
         dmem_we    = 1'b1;
         dmem_waddr = idx_ff;
         dmem_wdata = (idx_ff == '0) ? '0 : DIST_INF;
      end
   end

   always_ff @(posedge clock) begin
      if (dmem_we) dmem[dmem_waddr] <= dmem_wdata;
      d_q <= dmem[idx_ff];
   end

   // stage 1: relax against the chosen vertex
   logic                     vis1, relax1;
   logic [SW-1:0]            sum1;
   logic [DISTANCE_BITS-1:0] sat1, new1;

   always_comb begin
      vis1   = vis_ff[s1_idx_ff];
      sum1   = SW'(du_ff) + SW'(w_q);
      sat1   = (sum1 >= SW'(DIST_INF)) ? (DIST_INF - 1'b1) : sum1[DISTANCE_BITS-1:0];
      relax1 = !vis1 && (w_q != '0) && (du_ff != DIST_INF) && (d_q > sat1);
      new1   = relax1 ? sat1 : d_q;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff  <= 1'b0;
         s1_emit_ff <= 1'b0;
         s2_vld_ff  <= 1'b0;
      end else begin
         s1_vld_ff  <= (cmd.op == DP_RELAX) || (cmd.op == DP_EMIT);
         s1_emit_ff <= (cmd.op == DP_EMIT);
         s2_vld_ff  <= s1_vld_ff && !s1_emit_ff;
      end
   end

   always_ff @(posedge clock) begin
      s1_idx_ff  <= idx_ff;
      s1_last_ff <= idx_hit;
      s2_idx_ff  <= s1_idx_ff;
      s2_last_ff <= s1_last_ff;
      s2_vis_ff  <= vis1;
      s2_dist_ff <= new1;
   end

   // stage 2: closest unvisited vertex, lowest index on ties
   logic                     take2, found_next, commit;
   logic [VW-1:0]            cand_idx_next;
   logic [DISTANCE_BITS-1:0] cand_dist_next;

   always_comb begin
      take2          = s2_vld_ff && !s2_vis_ff && (!found_ff || (s2_dist_ff < cand_dist_ff));
      found_next     = found_ff || take2;
      cand_idx_next  = take2 ? s2_idx_ff : cand_idx_ff;
      cand_dist_next = take2 ? s2_dist_ff : cand_dist_ff;
      commit         = s2_vld_ff && s2_last_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vis_ff   <= '0;
         u_ff     <= '0;
         du_ff    <= '0;
         round_ff <= '0;
         found_ff <= 1'b0;
      end else if (cmd.op == DP_LOAD && req.command == CMD_RUN) begin
         vis_ff   <= {{(MAX_VERTICES-1){1'b0}}, 1'b1};
         u_ff     <= '0;
         du_ff    <= '0;
         round_ff <= '0;
         found_ff <= 1'b0;
      end else if (commit) begin
         vis_ff[cand_idx_next] <= 1'b1;
         u_ff     <= cand_idx_next;
         du_ff    <= cand_dist_next;
         round_ff <= round_ff + 1'b1;
         found_ff <= 1'b0;
      end else begin
         found_ff <= found_next;
      end
   end

   always_ff @(posedge clock) begin
      cand_idx_ff  <= cand_idx_next;
      cand_dist_ff <= cand_dist_next;
   end

   // status and result word
   logic [VW+VTX_W-1:0]              vo_ext;
   logic [DISTANCE_BITS+DIST_OUT_W-1:0] do_ext;

   assign vo_ext = {{VTX_W{1'b0}}, s1_idx_ff};
   assign do_ext = {{DIST_OUT_W{1'b0}}, d_q};

   always_comb begin
      status.idx_last    = idx_hit;
      status.clr_last    = &clr_ff;
      status.pipe_busy   = s1_vld_ff || s2_vld_ff;
      status.rounds_done = (round_ff == last_idx);
      rsp_valid          = s1_vld_ff && s1_emit_ff;
      rsp.vertex_index   = vo_ext[VTX_W-1:0];
      rsp.path_distance  = do_ext[DIST_OUT_W-1:0];
      rsp.last_vertex    = s1_last_ff;
   end

`ifndef NO_ASSERTIONS
   a_emit_apart: assert property (@(posedge clock) disable iff (reset)
      (s1_vld_ff && s1_emit_ff) |-> !s2_vld_ff)
      else $error("emit pass overlaps relax pipeline");
   a_round_pick: assert property (@(posedge clock) disable iff (reset)
      commit |-> found_next)
      else $error("round ended with no unvisited vertex");
   a_pick_unvisited: assert property (@(posedge clock) disable iff (reset)
      commit |-> !vis_ff[cand_idx_next])
      else $error("chosen vertex already visited");
   a_last_word: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp.last_vertex) |=> !rsp_valid)
      else $error("word after last word of run");
`endif

endmodule

// ===== src/dense_graph_shortest_path_unit.sv =====
// Dense-graph shortest path unit: top level with the configuration register.
// Depends on dgsp_pkg, dgsp_ctrl and dgsp_datapath.
//
// A command word is taken when start is high and busy is low. Set edge keeps
// busy after acceptance for one weight-memory write per direction. Clear
// sweeps the weight memory one entry per cycle, all 2^(2*ceil(log2
// MAX_VERTICES)) entries (4096 at the default); the same sweep runs after
// reset, with busy high. A run with n active vertices seeds the distance
// table, then in each of n-1 rounds passes over the vertices through the
// single distance-table port and drains the relax/select pipe, then makes
// the result pass. Results come one word per cycle, vertex 0 first, marked
// by rsp_valid for one cycle each; the receiver cannot stall them. The user
// must write vertex_count only while idle; the block does not enforce it.
module dense_graph_shortest_path_unit import dgsp_pkg::*; #(
   parameter int MAX_VERTICES  = 64,
   parameter int WEIGHT_BITS   = 16,
   parameter int DISTANCE_BITS = 24
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  req_type               req_data,
   output logic                  rsp_valid,
   output rsp_type               rsp_data,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   logic [COUNT_W-1:0] count_ff, count_in;
   logic               csr_wr;

   // byte offset within the word is ignored on writes
   assign csr_wr = csr_psel && csr_penable && csr_pwrite && csr_pready &&
                   ({csr_paddr[CSR_ADDR_W-1:2], 2'b00} == CSR_VERTEX_COUNT);

   assign count_in   = csr_wr ? csr_pwdata[COUNT_W-1:0] : count_ff;
   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr == CSR_VERTEX_COUNT) ? CSR_DATA_W'(count_ff) : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= VERTEX_COUNT_RESET;
      end else begin
         count_ff <= count_in;
      end
   end

   dp_cmd_type    dp_cmd;
   dp_status_type dp_status;

   dgsp_ctrl u_ctrl (
      .clock   (clock),
      .reset   (reset),
      .start   (start),
      .command (req_data.command),
      .status  (dp_status),
      .cmd     (dp_cmd),
      .busy    (busy)
   );

   dgsp_datapath #(
      .MAX_VERTICES  (MAX_VERTICES),
      .WEIGHT_BITS   (WEIGHT_BITS),
      .DISTANCE_BITS (DISTANCE_BITS)
   ) u_datapath (
      .clock        (clock),
      .reset        (reset),
      .cmd          (dp_cmd),
      .status       (dp_status),
      .req          (req_data),
      .vertex_count (count_ff),
      .rsp_valid    (rsp_valid),
      .rsp          (rsp_data)
   );

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
// Testbench for dense_graph_shortest_path_unit: directed and random command words,
// a shortest-path predictor and result checks. Depends on dgsp_pkg and the unit's RTL.
module tb_top import dgsp_pkg::*; ();

   localparam int MAX_VTX = 64;
   localparam int DRAIN_PAUSE = 8;
   localparam int ITEMS_PER_PHASE = 42;
   localparam logic [DIST_OUT_W-1:0] DIST_INF = '1;
   localparam logic [CMD_W-1:0] CMD_SPARE = 2'd3;

   // Tracks the edge matrix and the vertex count, and holds the distances still to arrive.
   class path_scoreboard;
      logic [WGT_IN_W-1:0] weight_mat [MAX_VTX][MAX_VTX];
      int unsigned count_reg;
      rsp_type dist_q[$];
      int unsigned mismatches;

      function new();
         clear_edges();
         count_reg = int'(VERTEX_COUNT_RESET);
         mismatches = 0;
      endfunction

      function void clear_edges();
         foreach (weight_mat[i, j]) weight_mat[i][j] = '0;
      endfunction

      function int pending();
         return dist_q.size();
      endfunction

      function void solve_paths();
         logic [DIST_OUT_W-1:0] dist_tbl [MAX_VTX];
         bit done_mark [MAX_VTX];
         logic [DIST_OUT_W:0] sum;
         int unsigned n, pick, i, r;
         bit found;
         rsp_type word;
         n = (count_reg < 2) ? 2 : ((count_reg > MAX_VTX) ? MAX_VTX : count_reg);
         for (i = 0; i < n; i++) begin
            done_mark[i] = 1'b0;
            dist_tbl[i] = (i == 0) ? '0 : DIST_INF;
         end
         for (r = 0; r + 1 < n; r++) begin
            pick = 0;
            found = 1'b0;
            for (i = 0; i < n; i++) begin
               if (!done_mark[i] && (!found || dist_tbl[i] < dist_tbl[pick])) begin
                  pick = i;
                  found = 1'b1;
               end
            end
            done_mark[pick] = 1'b1;
            // no relaxation out of an unreachable vertex
            if (dist_tbl[pick] != DIST_INF) begin
               for (i = 0; i < n; i++) begin
                  if (!done_mark[i] && weight_mat[pick][i] != '0) begin
                     sum = dist_tbl[pick] + weight_mat[pick][i];
                     if (sum >= DIST_INF) sum = {1'b0, DIST_INF - 1'b1};
                     if (dist_tbl[i] > sum) dist_tbl[i] = sum[DIST_OUT_W-1:0];
                  end
               end
            end
         end
         for (i = 0; i < n; i++) begin
            word.vertex_index  = VTX_W'(i);
            word.path_distance = dist_tbl[i];
            word.last_vertex   = (i + 1 == n);
            dist_q.push_back(word);
         end
      endfunction

      function void note_request(req_type word);
         case (word.command)
            CMD_CLEAR: clear_edges();
            CMD_SET: begin
               weight_mat[word.endpoint_a][word.endpoint_b] = word.edge_weight;
               weight_mat[word.endpoint_b][word.endpoint_a] = word.edge_weight;
            end
            CMD_RUN: solve_paths();
            default: ;
         endcase
      endfunction

      task report(string msg);
         $display("tb_top: mismatch: %s", msg);
         mismatches++;
      endtask

      task check_result(rsp_type got);
         rsp_type want;
         if (dist_q.size() == 0) begin
            report($sformatf("unexpected result word, vertex %0d", got.vertex_index));
            return;
         end
         want = dist_q.pop_front();
         if (got.vertex_index !== want.vertex_index)
            report($sformatf("vertex_index %0d, want %0d", got.vertex_index,
                             want.vertex_index));
         if (got.path_distance !== want.path_distance)
            report($sformatf("vertex %0d path_distance %h, want %h", want.vertex_index,
                             got.path_distance, want.path_distance));
         if (got.last_vertex !== want.last_vertex)
            report($sformatf("vertex %0d last_vertex %b, want %b", want.vertex_index,
                             got.last_vertex, want.last_vertex));
      endtask
   endclass

   logic                  clock;
   logic                  reset;
   logic                  start;
   logic                  busy;
   req_type               req_data;
   logic                  rsp_valid;
   rsp_type               rsp_data;
   logic                  csr_psel;
   logic                  csr_penable;
   logic                  csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [CSR_DATA_W-1:0] csr_pwdata;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   path_scoreboard sb = new();
   int unsigned burst_left = 0;
   int unsigned phase_counts [10] = '{3, 8, 2, 12, 64, 20, 6, 33, 16, 10};
   int unsigned p, k, wait_cycles;

   dense_graph_shortest_path_unit u_dut (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .busy        (busy),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_data    (rsp_data),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // sender: bursts of random length separated by random gaps
   task automatic send_item(req_type word);
      int unsigned gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
         if (gap != 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      start <= 1'b1;
      req_data <= word;
      do @(posedge clock); while (busy);
      sb.note_request(word);
      burst_left--;
   endtask

   task automatic issue(logic [CMD_W-1:0] cmd, logic [VTX_W-1:0] a, logic [VTX_W-1:0] b,
                        logic [WGT_IN_W-1:0] w);
      req_type word;
      word.command     = cmd;
      word.endpoint_a  = a;
      word.endpoint_b  = b;
      word.edge_weight = w;
      send_item(word);
   endtask

   // write vertex_count once the unit is idle, then read it back
   task automatic set_count(logic [CSR_DATA_W-1:0] value);
      start <= 1'b0;
      do @(posedge clock); while (sb.pending() != 0);
      repeat (DRAIN_PAUSE) @(posedge clock);
      do @(posedge clock); while (busy);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= CSR_VERTEX_COUNT;
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      sb.count_reg = int'(value[COUNT_W-1:0]);
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      if (csr_prdata !== CSR_DATA_W'(value[COUNT_W-1:0]))
         sb.report($sformatf("vertex_count reads %h, want %h", csr_prdata,
                             value[COUNT_W-1:0]));
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      burst_left = 0;
   endtask

   // mostly edge loads inside the active vertices, some runs, some noise
   function automatic req_type random_item(int unsigned n);
      req_type word;
      int unsigned sel, wsel;
      word.command     = CMD_SET;
      word.endpoint_a  = VTX_W'($urandom_range(0, MAX_VTX - 1));
      word.endpoint_b  = VTX_W'($urandom_range(0, MAX_VTX - 1));
      word.edge_weight = WGT_IN_W'($urandom_range(0, 65535));
      sel = $urandom_range(0, 99);
      if (sel < 3) word.command = CMD_CLEAR;
      else if (sel < 6) word.command = CMD_SPARE;
      else if (sel < 16) word.command = CMD_RUN;
      else if (sel >= 24) begin
         word.endpoint_a = VTX_W'($urandom_range(0, n - 1));
         word.endpoint_b = VTX_W'($urandom_range(0, n - 1));
         wsel = $urandom_range(0, 19);
         if (wsel < 3) word.edge_weight = '0;
         else if (wsel >= 6) word.edge_weight = WGT_IN_W'($urandom_range(1, 16));
      end
      return word;
   endfunction

   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1) sb.check_result(rsp_data);
   end

   initial begin
      reset       <= 1'b1;
      start       <= 1'b0;
      req_data    <= '0;
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      csr_paddr   <= '0;
      csr_pwdata  <= '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // directed: empty graph, edge overwrite and removal, self loop, spare command
      issue(CMD_RUN, 6'd0, 6'd0, 16'd0);
      issue(CMD_SET, 6'd0, 6'd1, 16'd1);
      issue(CMD_SET, 6'd1, 6'd63, 16'hFFFF);
      issue(CMD_SET, 6'd5, 6'd5, 16'd7);
      issue(CMD_SET, 6'd0, 6'd2, 16'hFFFF);
      issue(CMD_SET, 6'd2, 6'd0, 16'd0);
      issue(CMD_SPARE, 6'h3F, 6'h3F, 16'hFFFF);
      issue(CMD_SET, 6'd3, 6'd1, 16'd2);
      issue(CMD_RUN, 6'h3F, 6'h3F, 16'hFFFF);
      set_count(32'd2);
      issue(CMD_RUN, 6'd0, 6'd0, 16'd0);
      issue(CMD_SET, 6'd0, 6'd1, 16'd0);
      issue(CMD_RUN, 6'd0, 6'd0, 16'd0);
      // counts below 2 act as 2, above 64 as 64
      set_count(32'd0);
      issue(CMD_SET, 6'd0, 6'd1, 16'hFFFF);
      issue(CMD_RUN, 6'd0, 6'd0, 16'd0);
      set_count(32'd1);
      issue(CMD_RUN, 6'd0, 6'd0, 16'd0);
      set_count(32'd127);
      issue(CMD_RUN, 6'd0, 6'd0, 16'd0);
      // upper bits of the write data are dropped: count 5
      set_count(32'hFFFF_FF85);
      issue(CMD_CLEAR, 6'h3F, 6'h3F, 16'hFFFF);
      issue(CMD_SET, 6'd0, 6'd4, 16'd9);
      issue(CMD_SET, 6'd4, 6'd3, 16'd1);
      issue(CMD_SET, 6'd3, 6'd2, 16'd1);
      issue(CMD_SET, 6'd0, 6'd2, 16'd20);
      issue(CMD_SET, 6'd62, 6'd63, 16'd5);
      issue(CMD_RUN, 6'd0, 6'd0, 16'd0);

      for (p = 0; p < 10; p++) begin
         set_count(CSR_DATA_W'(phase_counts[p]));
         if ($urandom_range(0, 1) == 1) issue(CMD_CLEAR, 6'd0, 6'd0, 16'd0);
         for (k = 0; k < ITEMS_PER_PHASE; k++) send_item(random_item(phase_counts[p]));
         issue(CMD_RUN, 6'd0, 6'd0, 16'd0);
      end

      start <= 1'b0;
      wait_cycles = 0;
      do begin
         @(posedge clock);
         wait_cycles++;
      end while (sb.pending() != 0 && wait_cycles < 20000);
      repeat (4 * DRAIN_PAUSE) @(posedge clock);
      if (sb.pending() != 0)
         sb.report($sformatf("%0d result words never arrived", sb.pending()));
      if (sb.mismatches == 0) begin
         $display("tb_top: done, clean");
      end else begin
         $display("tb_top: done, errors");
      end
      $finish;
   end

   initial begin
      #40_000_000;
      $display("tb_top: done, errors");
      $finish;
   end

endmodule

// ===== dense_graph_shortest_path_unit.f =====
src/dgsp_pkg.sv
src/dgsp_ctrl.sv
src/dgsp_datapath.sv
src/dense_graph_shortest_path_unit.sv
tb/tb_top.sv
